[sv/spf_pkg.sv]
// shared types and constants for the matrix saddle point finder
package spf_pkg;

  // parameter defaults
  localparam int MAX_ROWS_DEF   = 8;
  localparam int MAX_COLS_DEF   = 8;
  localparam int DATA_WIDTH_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
  localparam int DIM_RESET = 8;

  // result field widths
  localparam int ROW_OUT_W = 3;
  localparam int COL_OUT_W = 3;
  localparam int ORD_OUT_W = 7;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_PAD_W = OUT_DATA_W - ROW_OUT_W - COL_OUT_W - ORD_OUT_W - 1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_LOAD_WR,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_FINISH
  } spf_state_e;

  // flags from the shared compare unit
  typedef struct packed {
    logic gt0;
    logic lt1;
    logic eq0;
    logic eq1;
  } spf_cmp_t;

endpackage

[sv/spf_ram.sv]
// generic single write port ram with registered read
module spf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/spf_cmp.sv]
// shared signed compare unit used by both the load and the walk
module spf_cmp import spf_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic signed [DATA_WIDTH-1:0] x_i,
  input  logic signed [DATA_WIDTH-1:0] y0_i,
  input  logic signed [DATA_WIDTH-1:0] y1_i,
  output spf_cmp_t                     flags_o
);

  // x against the row entry and against the column entry
  always_comb begin
    flags_o.gt0 = x_i > y0_i;
    flags_o.lt1 = x_i < y1_i;
    flags_o.eq0 = x_i == y0_i;
    flags_o.eq1 = x_i == y1_i;
  end

endmodule

[sv/matrix_saddle_point_finder_top.sv]
// top level of the matrix saddle point finder
//
// Input stream s_axis carries one signed matrix element per transfer in
// row-major order (tdata bits [15:0]). After row_count * col_count elements
// the stored matrix is scanned and m_axis returns one result per saddle point
// (an element equal to its row maximum and its column minimum), tlast on the
// final one; with no saddle point a single result with found = 0 is sent.
// The cfg channel writes row_count (index 0) or col_count (index 1); any such
// write restarts the load. Writes must go in only while the block is idle;
// the block itself does not enforce it. Each element is loaded as a read of
// the row maximum and column minimum memories, then the compare and write-back
// through the shared compare unit. The scan reads each stored entry, then
// compares it; it sends the final result before input is taken again.
// Results are held one behind in a hold register so that tlast can be set;
// a stalled receiver stops the scan at the next saddle point found.
// Reset restores 8 by 8 dimensions and an empty load; the stores need no
// clearing since every entry read is written during the same load.
module matrix_saddle_point_finder_top import spf_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // element stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: element_value
  input  logic [((DATA_WIDTH > 16 ? DATA_WIDTH : 16) + 7) / 8 * 8 - 1:0] s_axis_tdata_i,
  // result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // tdata: point_row, point_col, ordinal, found, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tlast_o,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DAT_W-1:0]  cfg_data_i
);

  localparam int ROW_W  = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W  = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int ORD_W  = $clog2(DEPTH + 1);
  localparam int ROW_LAST_RST = (DIM_RESET > MAX_ROWS ? MAX_ROWS : DIM_RESET) - 1;
  localparam int COL_LAST_RST = (DIM_RESET > MAX_COLS ? MAX_COLS : DIM_RESET) - 1;

  spf_state_e state_q, state_d;

  logic [ROW_W-1:0] row_last_q, row_last_d;
  logic [COL_W-1:0] col_last_q, col_last_d;
  logic [ROW_W-1:0] r_q;
  logic [COL_W-1:0] c_q;
  logic signed [DATA_WIDTH-1:0] elem_q;
  logic [ORD_W-1:0] ord_q;

  logic             hold_valid_q;
  logic [ROW_W-1:0] hold_row_q;
  logic [COL_W-1:0] hold_col_q;
  logic [ORD_W-1:0] hold_ord_q;

  logic                 out_valid_q;
  logic [ROW_OUT_W-1:0] out_row_q;
  logic [COL_OUT_W-1:0] out_col_q;
  logic [ORD_OUT_W-1:0] out_ord_q;
  logic                 out_found_q;
  logic                 out_last_q;

  logic cfg_row_we, cfg_col_we, cfg_we;
  logic in_accept, out_free, at_end, match, stall;
  logic wr_mat, wr_rmax, wr_cmin, adv, take, push_hold, push_final;

  logic [ADDR_W-1:0] mat_addr;
  logic signed [DATA_WIDTH-1:0] mat_rdata, rmax_rdata, cmin_rdata, cmp_x;
  spf_cmp_t cmp;

  // configuration decode, always accepted
  assign cfg_ready_o = 1'b1;
  assign cfg_row_we  = cfg_valid_i && (cfg_index_i == CFG_ROW_COUNT);
  assign cfg_col_we  = cfg_valid_i && (cfg_index_i == CFG_COL_COUNT);
  assign cfg_we      = cfg_row_we || cfg_col_we;

  // clamp written dimensions to 1..max, kept as last index
  always_comb begin
    if (cfg_data_i == '0) begin
      row_last_d = '0;
    end else if (32'(cfg_data_i) > MAX_ROWS) begin
      row_last_d = ROW_W'(MAX_ROWS - 1);
    end else begin
      row_last_d = ROW_W'(cfg_data_i - 1'b1);
    end
    if (cfg_data_i == '0) begin
      col_last_d = '0;
    end else if (32'(cfg_data_i) > MAX_COLS) begin
      col_last_d = COL_W'(MAX_COLS - 1);
    end else begin
      col_last_d = COL_W'(cfg_data_i - 1'b1);
    end
  end

  // shared status
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign at_end    = (r_q == row_last_q) && (c_q == col_last_q);
  assign match     = cmp.eq0 && cmp.eq1;
  assign stall     = match && hold_valid_q && !out_free;
  assign mat_addr  = ADDR_W'(32'(r_q) * MAX_COLS + 32'(c_q));

  // storage for matrix, row maxima and column minima
  spf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_mat_ram (
    .clk_i   (clk_i),
    .we_i    (wr_mat),
    .waddr_i (mat_addr),
    .wdata_i (elem_q),
    .raddr_i (mat_addr),
    .rdata_o (mat_rdata)
  );

  spf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ROWS)) u_rmax_ram (
    .clk_i   (clk_i),
    .we_i    (wr_rmax),
    .waddr_i (r_q),
    .wdata_i (elem_q),
    .raddr_i (r_q),
    .rdata_o (rmax_rdata)
  );

  spf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_COLS)) u_cmin_ram (
    .clk_i   (clk_i),
    .we_i    (wr_cmin),
    .waddr_i (c_q),
    .wdata_i (elem_q),
    .raddr_i (c_q),
    .rdata_o (cmin_rdata)
  );

  // compare unit, fed by the new element while loading, the store while scanning
  assign cmp_x = (state_q == ST_LOAD_WR) ? elem_q : mat_rdata;

  spf_cmp #(.DATA_WIDTH(DATA_WIDTH)) u_cmp (
    .x_i     (cmp_x),
    .y0_i    (rmax_rdata),
    .y1_i    (cmin_rdata),
    .flags_o (cmp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_accept) state_d = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        state_d = at_end ? ST_WALK_RD : ST_LOAD;
      end
      ST_WALK_RD: begin
        state_d = ST_WALK_CMP;
      end
      ST_WALK_CMP: begin
        if (!stall) state_d = at_end ? ST_FINISH : ST_WALK_RD;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_LOAD;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    wr_mat     = 1'b0;
    wr_rmax    = 1'b0;
    wr_cmin    = 1'b0;
    adv        = 1'b0;
    take       = 1'b0;
    push_hold  = 1'b0;
    push_final = 1'b0;
    case (state_q)
      ST_LOAD: begin
        s_axis_tready_o = 1'b1;
      end
      ST_LOAD_WR: begin
        wr_mat  = 1'b1;
        wr_rmax = (c_q == '0) || cmp.gt0;
        wr_cmin = (r_q == '0) || cmp.lt1;
        adv     = 1'b1;
      end
      ST_WALK_CMP: begin
        if (!stall) begin
          adv       = 1'b1;
          take      = match;
          push_hold = match && hold_valid_q;
        end
      end
      ST_FINISH: begin
        push_final = out_free;
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  // state, dimensions and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      row_last_q <= ROW_W'(ROW_LAST_RST);
      col_last_q <= COL_W'(COL_LAST_RST);
      r_q        <= '0;
      c_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_row_we) row_last_q <= row_last_d;
      if (cfg_col_we) col_last_q <= col_last_d;
      if (cfg_we) begin
        r_q <= '0;
        c_q <= '0;
      end else if (adv) begin
        if (c_q == col_last_q) begin
          c_q <= '0;
          r_q <= (r_q == row_last_q) ? '0 : r_q + 1'b1;
        end else begin
          c_q <= c_q + 1'b1;
        end
      end
    end
  end

  // element capture
  always_ff @(posedge clk_i) begin
    if (in_accept) elem_q <= s_axis_tdata_i[DATA_WIDTH-1:0];
  end

  // ordinal count and hold register, one result behind the output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      ord_q        <= '0;
    end else begin
      if (state_q == ST_LOAD_WR && at_end) begin
        hold_valid_q <= 1'b0;
        ord_q        <= '0;
      end else if (take) begin
        hold_valid_q <= 1'b1;
        ord_q        <= ord_q + 1'b1;
      end else if (push_final) begin
        hold_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hold_row_q <= r_q;
      hold_col_q <= c_q;
      hold_ord_q <= ord_q + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_hold || push_final) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_hold || (push_final && hold_valid_q)) begin
      out_row_q   <= ROW_OUT_W'(hold_row_q);
      out_col_q   <= COL_OUT_W'(hold_col_q);
      out_ord_q   <= ORD_OUT_W'(hold_ord_q);
      out_found_q <= 1'b1;
      out_last_q  <= push_final;
    end else if (push_final) begin
      out_row_q   <= '0;
      out_col_q   <= '0;
      out_ord_q   <= '0;
      out_found_q <= 1'b0;
      out_last_q  <= 1'b1;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_found_q, out_ord_q, out_col_q, out_row_q};

`ifndef SYNTH
  // a held saddle point always carries a nonzero ordinal
  a_hold_ord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_valid_q |-> hold_ord_q != '0)
    else $error("held result without ordinal");

  // sending the final result always shows a marked transfer next
  a_final_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free) |=> (m_axis_tvalid_o && m_axis_tlast_o))
    else $error("final result not marked last");

  // a none-found result is always marked last
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[ROW_OUT_W + COL_OUT_W + ORD_OUT_W]) |-> m_axis_tlast_o)
    else $error("none-found result without last");

  // position stays inside the configured matrix
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_q <= row_last_q) && (c_q <= col_last_q))
    else $error("position outside matrix");
`endif

endmodule
